// ----- src/mvt_pkg.sv -----
// Shared widths, types, reset matrix and helpers for the matrix-vector transform.
package mvt_pkg;

  localparam int unsigned NumRows   = 4;
  localparam int unsigned NumCols   = 4;
  localparam int unsigned CompW     = 32;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned RowW      = NumCols * CoefW;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned FracShift = 12;
  localparam int unsigned ProdW     = CompW + CoefW;
  localparam int unsigned PairW     = ProdW + 1;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned RndW      = SumW - FracShift;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic        [RowW-1:0]  row_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [PairW-1:0] pair_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [RndW-1:0]  rnd_t;
  typedef logic [CfgIdxW-1:0]      cfg_idx_t;

  // Register indexes of the four matrix rows.
  typedef enum logic [CfgIdxW-1:0] {
    RegRow0 = 2'd0,
    RegRow1 = 2'd1,
    RegRow2 = 2'd2,
    RegRow3 = 2'd3
  } cfg_reg_e;

  // Identity matrix, 1.0 in Q4.12 on the diagonal.
  localparam row_t RowReset [NumRows] = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_1000_0000,
    64'h0000_1000_0000_0000,
    64'h1000_0000_0000_0000
  };

  // Half an LSB of the Q16.16 result, seen in the Q22.28 sum.
  localparam sum_t RoundHalf = SumW'(1) <<< (FracShift - 1);

  // Clip a rounded value to 32 signed bits.
  function automatic comp_t sat_comp(input rnd_t v);
    logic [RndW-CompW:0] top;
    comp_t               res;
    top = v[RndW-1:CompW-1];
    if (top == '0 || top == '1) begin
      res = comp_t'(v[CompW-1:0]);
    end else if (v[RndW-1]) begin
      res = {1'b1, {(CompW-1){1'b0}}};
    end else begin
      res = {1'b0, {(CompW-1){1'b1}}};
    end
    return res;
  endfunction

  // True when a rounded value lies outside 32 signed bits.
  function automatic logic is_clipped(input rnd_t v);
    logic [RndW-CompW:0] top;
    top = v[RndW-1:CompW-1];
    return !(top == '0 || top == '1);
  endfunction

endpackage

// ----- src/mvt_vec_if.sv -----
// Input vector channel: valid/ready with four Q16.16 components.
interface mvt_vec_if;
  logic          valid;
  logic          ready;
  mvt_pkg::comp_t in_x;
  mvt_pkg::comp_t in_y;
  mvt_pkg::comp_t in_z;
  mvt_pkg::comp_t in_w;

  modport source (output valid, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

// ----- src/mvt_res_if.sv -----
// Result channel: valid/ready with four Q16.16 components and a clip flag.
interface mvt_res_if;
  logic           valid;
  logic           ready;
  mvt_pkg::comp_t out_x;
  mvt_pkg::comp_t out_y;
  mvt_pkg::comp_t out_z;
  mvt_pkg::comp_t out_w;
  logic           saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

// ----- src/mvt_cfg_if.sv -----
// Configuration write channel: valid/ready with register index and data.
interface mvt_cfg_if;
  logic               valid;
  logic               ready;
  mvt_pkg::cfg_idx_t  index;
  mvt_pkg::row_t      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/matrix_vector_transform_core.sv -----
// Four-stage pipelined 4x4 Q4.12 matrix by Q16.16 vector transform.
//
//   channel | dir | payload                                  | beat
//   vec_i   | in  | in_x, in_y, in_z, in_w                   | valid & ready
//   res_o   | out | out_x, out_y, out_z, out_w, saturated    | valid & ready
//   cfg_i   | in  | index (row 0..3), data (four Q4.12 coefs)| valid & ready
//
// One vector enters per cycle unless a stall at res_o backs up the stages.
// Stages: 16 products, pair sums, final sum with rounding, clip to 32 bits.
// Each stage holds while the next one is full and stalled, so a stall at
// res_o backs up through the valid bits without dropping a beat.
// Reset clears the valid bits and loads the identity matrix; cfg_i is
// always ready.
module matrix_vector_transform_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  mvt_vec_if.sink        vec_i,
  mvt_res_if.source      res_o,
  mvt_cfg_if.sink        cfg_i
);

  mvt_pkg::row_t  rows_q [mvt_pkg::NumRows];
  mvt_pkg::comp_t vec    [mvt_pkg::NumCols];

  mvt_pkg::prod_t prod_d [mvt_pkg::NumRows][mvt_pkg::NumCols];
  mvt_pkg::prod_t prod_q [mvt_pkg::NumRows][mvt_pkg::NumCols];
  mvt_pkg::pair_t pair_d [mvt_pkg::NumRows][2];
  mvt_pkg::pair_t pair_q [mvt_pkg::NumRows][2];
  mvt_pkg::rnd_t  rnd_d  [mvt_pkg::NumRows];
  mvt_pkg::rnd_t  rnd_q  [mvt_pkg::NumRows];
  mvt_pkg::comp_t res_d  [mvt_pkg::NumRows];
  mvt_pkg::comp_t res_q  [mvt_pkg::NumRows];
  logic           sat_d, sat_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // Matrix registers: writes to a row replace all four coefficients.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < mvt_pkg::NumRows; r++) begin
        rows_q[r] <= mvt_pkg::RowReset[r];
      end
    end else if (cfg_i.valid) begin
      case (mvt_pkg::cfg_reg_e'(cfg_i.index))
        mvt_pkg::RegRow0: rows_q[0] <= cfg_i.data;
        mvt_pkg::RegRow1: rows_q[1] <= cfg_i.data;
        mvt_pkg::RegRow2: rows_q[2] <= cfg_i.data;
        mvt_pkg::RegRow3: rows_q[3] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage takes a beat when empty or when it moves on.
  assign rdy4        = !v4_q || res_o.ready;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign vec_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= vec_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: sixteen 16x32 products.
  assign vec[0] = vec_i.in_x;
  assign vec[1] = vec_i.in_y;
  assign vec[2] = vec_i.in_z;
  assign vec[3] = vec_i.in_w;

  always_comb begin
    for (int r = 0; r < mvt_pkg::NumRows; r++) begin
      for (int k = 0; k < mvt_pkg::NumCols; k++) begin
        prod_d[r][k] = mvt_pkg::ProdW'(mvt_pkg::coef_t'(rows_q[r][k*mvt_pkg::CoefW +:
                                                        mvt_pkg::CoefW]))
                     * mvt_pkg::ProdW'(vec[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && vec_i.valid) prod_q <= prod_d;
  end

  // Stage 2: add products in pairs.
  always_comb begin
    for (int r = 0; r < mvt_pkg::NumRows; r++) begin
      pair_d[r][0] = mvt_pkg::PairW'(prod_q[r][0]) + mvt_pkg::PairW'(prod_q[r][1]);
      pair_d[r][1] = mvt_pkg::PairW'(prod_q[r][2]) + mvt_pkg::PairW'(prod_q[r][3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) pair_q <= pair_d;
  end

  // Stage 3: final sum, add half an LSB, drop the extra fraction bits.
  always_comb begin
    mvt_pkg::sum_t s;
    for (int r = 0; r < mvt_pkg::NumRows; r++) begin
      s = mvt_pkg::SumW'(pair_q[r][0]) + mvt_pkg::SumW'(pair_q[r][1]) + mvt_pkg::RoundHalf;
      rnd_d[r] = mvt_pkg::rnd_t'(s[mvt_pkg::SumW-1:mvt_pkg::FracShift]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) rnd_q <= rnd_d;
  end

  // Stage 4: clip to 32 bits and flag any clipped component.
  always_comb begin
    sat_d = 1'b0;
    for (int r = 0; r < mvt_pkg::NumRows; r++) begin
      res_d[r] = mvt_pkg::sat_comp(rnd_q[r]);
      sat_d    = sat_d | mvt_pkg::is_clipped(rnd_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  // Drive the result beat from the last stage.
  assign res_o.valid     = v4_q;
  assign res_o.out_x     = res_q[0];
  assign res_o.out_y     = res_q[1];
  assign res_o.out_z     = res_q[2];
  assign res_o.out_w     = res_q[3];
  assign res_o.saturated = sat_q;

endmodule

// ----- tb/tb_matrix_vector_transform_core.sv -----
// Testbench for the 4x4 fixed-point matrix-vector transform core.
module tb_matrix_vector_transform_core;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned SqueezeCycles = 300;
  localparam int unsigned PhaseItems    = 320;

  localparam mvt_pkg::comp_t CompHi  = 32'h7FFF_FFFF;
  localparam mvt_pkg::comp_t CompLo  = 32'h8000_0000;
  localparam longint         SumHi   = 64'sd2147483647;
  localparam longint         SumLo   = -64'sd2147483648;
  localparam longint         HalfLsb = longint'(1) <<< (mvt_pkg::FracShift - 1);

  // Kinds of matrix loaded for a random phase.
  typedef enum logic [1:0] {
    MxFull,
    MxSmall,
    MxEdge,
    MxIdentity
  } mx_kind_e;

  typedef struct packed {
    mvt_pkg::comp_t x;
    mvt_pkg::comp_t y;
    mvt_pkg::comp_t z;
    mvt_pkg::comp_t w;
  } vec_t;

  typedef struct packed {
    mvt_pkg::comp_t x;
    mvt_pkg::comp_t y;
    mvt_pkg::comp_t z;
    mvt_pkg::comp_t w;
    logic           clipped;
  } xform_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mvt_vec_if vec_if ();
  mvt_res_if res_if ();
  mvt_cfg_if cfg_if ();

  matrix_vector_transform_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vec_i  (vec_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Matrix copy, vectors waiting to be sent, transforms waiting to arrive.
  mvt_pkg::row_t coef_rows [mvt_pkg::NumRows];
  vec_t          pending_vecs [$];
  xform_t        predicted_xforms [$];
  int unsigned   mismatches   = 0;
  int unsigned   cycle_count  = 0;
  int unsigned   send_gap     = 0;
  int unsigned   rcv_gap      = 0;
  logic          send_calm    = 1'b0;
  logic          rcv_calm     = 1'b0;
  logic          squeeze_req  = 1'b0;
  logic          squeeze      = 1'b0;

  // Clock: 4 high, 4 low.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Exact Q22.28 sums, round half up, clip to 32 signed bits.
  function automatic xform_t transform_vector(input vec_t v);
    longint         comp [mvt_pkg::NumCols];
    longint         acc;
    longint         rnd;
    mvt_pkg::coef_t c;
    mvt_pkg::comp_t lane [mvt_pkg::NumRows];
    logic           clip;
    xform_t         res;
    comp[0] = longint'(v.x);
    comp[1] = longint'(v.y);
    comp[2] = longint'(v.z);
    comp[3] = longint'(v.w);
    clip = 1'b0;
    for (int r = 0; r < mvt_pkg::NumRows; r++) begin
      acc = 0;
      for (int k = 0; k < mvt_pkg::NumCols; k++) begin
        c = coef_rows[r][mvt_pkg::CoefW*k +: mvt_pkg::CoefW];
        acc += longint'(c) * comp[k];
      end
      rnd = (acc + HalfLsb) >>> mvt_pkg::FracShift;
      if (rnd > SumHi) begin
        lane[r] = CompHi;
        clip = 1'b1;
      end else if (rnd < SumLo) begin
        lane[r] = CompLo;
        clip = 1'b1;
      end else begin
        lane[r] = mvt_pkg::comp_t'(rnd);
      end
    end
    res.x = lane[0];
    res.y = lane[1];
    res.z = lane[2];
    res.w = lane[3];
    res.clipped = clip;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic mvt_pkg::comp_t rand_comp();
    mvt_pkg::comp_t c;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: c = CompHi;
          1: c = CompLo;
          2: c = '0;
          default: c = '1;
        endcase
      end
      1, 2: c = mvt_pkg::comp_t'($urandom_range(0, 32'h3_FFFF))
                - mvt_pkg::comp_t'(32'h2_0000);
      default: c = mvt_pkg::comp_t'($urandom);
    endcase
    return c;
  endfunction

  function automatic mvt_pkg::row_t rand_row(input mx_kind_e kind, input int r);
    mvt_pkg::row_t  row;
    mvt_pkg::coef_t c;
    case (kind)
      MxFull: row = {$urandom, $urandom};
      MxSmall: begin
        for (int k = 0; k < mvt_pkg::NumCols; k++) begin
          c = mvt_pkg::coef_t'($urandom_range(0, 16'h2000)) - mvt_pkg::coef_t'(16'h1000);
          row[mvt_pkg::CoefW*k +: mvt_pkg::CoefW] = c;
        end
      end
      MxEdge: begin
        case ($urandom_range(0, 3))
          0: row = '0;
          1: row = '1;
          2: row = {mvt_pkg::NumCols{16'h7FFF}};
          default: row = {mvt_pkg::NumCols{16'h8000}};
        endcase
      end
      default: row = mvt_pkg::RowReset[r];
    endcase
    return row;
  endfunction

  // One register beat; hold valid until the core takes it.
  task automatic write_row(input mvt_pkg::cfg_reg_e idx, input mvt_pkg::row_t value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_matrix(input mvt_pkg::row_t r0, input mvt_pkg::row_t r1,
                              input mvt_pkg::row_t r2, input mvt_pkg::row_t r3);
    write_row(mvt_pkg::RegRow0, r0);
    write_row(mvt_pkg::RegRow1, r1);
    write_row(mvt_pkg::RegRow2, r2);
    write_row(mvt_pkg::RegRow3, r3);
  endtask

  task automatic queue_vec(input mvt_pkg::comp_t x, input mvt_pkg::comp_t y,
                           input mvt_pkg::comp_t z, input mvt_pkg::comp_t w);
    vec_t v;
    v = '{x: x, y: y, z: z, w: w};
    pending_vecs = {pending_vecs, v};
  endtask

  // Wait until every vector is sent and every transform has come back.
  // Sample on the falling edge, once all driver updates have settled.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_vecs.size() != 0 || vec_if.valid || predicted_xforms.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Track register beats in the local matrix copy.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      coef_rows <= mvt_pkg::RowReset;
    end else if (cfg_if.valid && cfg_if.ready) begin
      coef_rows[cfg_if.index] <= cfg_if.data;
    end
  end

  // Vector driver: predict on each accepted beat, then offer the next vector.
  always @(posedge clk_i) begin : vec_drive
    vec_t v;
    if (!rst_ni) begin
      vec_if.valid <= 1'b0;
      vec_if.in_x  <= '0;
      vec_if.in_y  <= '0;
      vec_if.in_z  <= '0;
      vec_if.in_w  <= '0;
    end else begin
      if (vec_if.valid && vec_if.ready) begin
        v = '{x: vec_if.in_x, y: vec_if.in_y, z: vec_if.in_z, w: vec_if.in_w};
        predicted_xforms = {predicted_xforms, transform_vector(v)};
      end
      if ($urandom_range(0, 49) == 0) begin
        send_calm = !send_calm;
      end
      // Hold a beat that is still waiting for ready.
      if (!(vec_if.valid && !vec_if.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          vec_if.valid <= 1'b0;
        end else if (pending_vecs.size() == 0) begin
          vec_if.valid <= 1'b0;
        end else if (!send_calm && $urandom_range(0, 3) == 0) begin
          send_gap = gap_len() - 1;
          vec_if.valid <= 1'b0;
        end else begin
          v = pending_vecs.pop_front();
          vec_if.valid <= 1'b1;
          vec_if.in_x  <= v.x;
          vec_if.in_y  <= v.y;
          vec_if.in_z  <= v.z;
          vec_if.in_w  <= v.w;
        end
      end
    end
  end

  // Result monitor: compare each beat with the oldest prediction, then pick ready.
  always @(posedge clk_i) begin : res_check
    xform_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (predicted_xforms.size() == 0) begin
          $error("result beat with no transform expected");
          mismatches++;
        end else begin
          want = predicted_xforms.pop_front();
          if (res_if.out_x !== want.x) begin
            $error("out_x: expected %h, got %h", want.x, res_if.out_x);
            mismatches++;
          end
          if (res_if.out_y !== want.y) begin
            $error("out_y: expected %h, got %h", want.y, res_if.out_y);
            mismatches++;
          end
          if (res_if.out_z !== want.z) begin
            $error("out_z: expected %h, got %h", want.z, res_if.out_z);
            mismatches++;
          end
          if (res_if.out_w !== want.w) begin
            $error("out_w: expected %h, got %h", want.w, res_if.out_w);
            mismatches++;
          end
          if (res_if.saturated !== want.clipped) begin
            $error("saturated: expected %b, got %b", want.clipped, res_if.saturated);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 49) == 0) begin
        rcv_calm = !rcv_calm;
      end
      if (squeeze) begin
        res_if.ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        res_if.ready <= 1'b0;
      end else if (!rcv_calm && $urandom_range(0, 3) == 0) begin
        rcv_gap = gap_len() - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the pipeline fills and stalls its input.
  initial begin
    wait (squeeze_req);
    @(posedge clk_i);
    squeeze <= 1'b1;
    repeat (SqueezeCycles) @(posedge clk_i);
    squeeze <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus: directed vectors under fixed matrices, then random phases.
  initial begin : stimulus
    mx_kind_e      phase_kinds [6];
    mvt_pkg::row_t rows [mvt_pkg::NumRows];
    phase_kinds = '{MxFull, MxSmall, MxEdge, MxSmall, MxFull, MxIdentity};
    cfg_if.valid = 1'b0;
    cfg_if.index = mvt_pkg::RegRow0;
    cfg_if.data  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Identity after reset: values pass through unchanged.
    queue_vec('0, '0, '0, '0);
    queue_vec(CompHi, CompHi, CompHi, CompHi);
    queue_vec(CompLo, CompLo, CompLo, CompLo);
    queue_vec('1, 32'sd1, 32'h0001_0000, 32'hFFFF_0000);
    drain();

    // Largest positive coefficients everywhere: clip both ways.
    write_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    queue_vec(CompHi, CompHi, CompHi, CompHi);
    queue_vec(CompLo, CompLo, CompLo, CompLo);
    queue_vec(32'sd1, 32'sd1, 32'sd1, 32'sd1);
    drain();

    // Most negative coefficients everywhere.
    write_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    queue_vec(CompLo, CompLo, CompLo, CompLo);
    queue_vec(CompHi, CompHi, CompHi, CompHi);
    queue_vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    drain();

    // Tiny and half coefficients: exact halves round up, others to nearest.
    write_matrix(64'h0000_0000_0000_0001, 64'h0000_0000_FFFF_0000,
                 64'h0000_0800_0000_0000, 64'h7FFF_8000_0001_FFFF);
    queue_vec(32'sh800, 32'sh800, 32'sd1, '0);
    queue_vec(-32'sh800, -32'sh800, -32'sd1, '0);
    queue_vec(32'sh7FF, 32'sh801, 32'sd3, '0);
    queue_vec(-32'sh801, -32'sh7FF, -32'sd3, '0);
    queue_vec(CompHi, CompLo, CompHi, CompLo);
    drain();

    // Random phases, each with a fresh matrix.
    foreach (phase_kinds[p]) begin
      for (int r = 0; r < mvt_pkg::NumRows; r++) begin
        rows[r] = rand_row(phase_kinds[p], r);
      end
      write_matrix(rows[0], rows[1], rows[2], rows[3]);
      for (int i = 0; i < PhaseItems; i++) begin
        queue_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
      if (p == 1) begin
        squeeze_req = 1'b1;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
